>>> src/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types for the sorted minimum priority queue: operation codes and
// the control bundle broadcast to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic shift_in;   // insert the new value in order
        logic shift_out;  // drop the head, move everything down
    } t_cell_ctl;

endpackage

>>> src/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain. Keeps its value when it is smaller than the
// value being inserted, otherwise takes the new value or its lower
// neighbour's value; on a pop it takes its upper neighbour's value.
// ----------------------------------------------------------------------------
module smpq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  smpq_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_occupied,
    input  logic signed [VALUE_WIDTH-1:0] i_new_value,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_value,
    input  logic                          i_prev_keep,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_keep
);
    import smpq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;

    assign o_keep  = i_occupied && (r_value < i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift_in) begin
            if (!o_keep) begin
                n_value = i_prev_keep ? i_new_value : i_prev_value;
            end
        end else if (i_ctl.shift_out) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> src/sorted_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Sorted minimum priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry an opcode and a signed value.
// A push inserts the value in ascending order, a pop removes the smallest
// entry. Output channel: o_out_valid / i_out_stall carry one result per
// transfer in: the minimum (zero when empty), a non-empty flag, the entry
// count and a flag for a push refused because all DEPTH slots are in use.
// Every cell updates in the same cycle as the input transfer and the result
// is registered, so one item is taken per cycle while the receiver does not
// stall; the critical path runs through the broadcast compare across the
// chain plus one level of selection in each cell.
// While the receiver stalls, the result is held and o_in_stall is raised, so
// the stored entries do not move. Reset empties the queue and clears the
// output valid; cell contents are left as they are and are never read while
// outside the entry count.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  smpq_pkg::t_op                        i_opcode,
    input  logic signed [VALUE_WIDTH-1:0]        i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]        o_min_value,
    output logic                                 o_has_entries,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count,
    output logic                                 o_push_dropped
);
    import smpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          r_dropped;
    logic          n_dropped;

    logic          in_xfer;
    logic          full;
    logic          empty;
    t_cell_ctl     cell_ctl;

    logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic                          cell_keep  [DEPTH];

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        cell_ctl.shift_in  = in_xfer && (i_opcode == OP_PUSH) && !full;
        cell_ctl.shift_out = in_xfer && (i_opcode == OP_POP) && !empty;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VALUE_WIDTH-1:0] prev_value;
            logic signed [VALUE_WIDTH-1:0] next_value;
            logic                          prev_keep;

            if (g == 0) begin : g_head
                assign prev_value = i_push_value;
                assign prev_keep  = 1'b1;
            end else begin : g_body
                assign prev_value = cell_value[g-1];
                assign prev_keep  = cell_keep[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign next_value = cell_value[g];
            end else begin : g_link
                assign next_value = cell_value[g+1];
            end

            smpq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_occupied   (r_count > CW'(g)),
                .i_new_value  (i_push_value),
                .i_prev_value (prev_value),
                .i_prev_keep  (prev_keep),
                .i_next_value (next_value),
                .o_value      (cell_value[g]),
                .o_keep       (cell_keep[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && i_out_stall;
        if (cell_ctl.shift_in) begin
            n_count = r_count + 1'b1;
        end else if (cell_ctl.shift_out) begin
            n_count = r_count - 1'b1;
        end
        if (in_xfer) begin
            n_out_valid = 1'b1;
            n_dropped   = (i_opcode == OP_PUSH) && full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dropped <= n_dropped;
    end

    assign o_out_valid    = r_out_valid;
    assign o_min_value    = empty ? '0 : cell_value[0];
    assign o_has_entries  = !empty;
    assign o_entry_count  = r_count;
    assign o_push_dropped = r_dropped;

    // count stays within the number of cells
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a refused push is only reported with a full store
    a_drop_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_dropped) |-> full)
        else $error("push dropped while space left");

    // push into a store with space grows the count by one
    a_push_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.shift_in |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow count");

    // pop from a non-empty store shrinks the count by one
    a_pop_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.shift_out |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not shrink count");

    // a push into an empty store becomes the minimum
    a_first_min : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_ctl.shift_in && empty) |=> (o_min_value == $past(i_push_value)))
        else $error("first pushed value not at head");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sorted minimum priority queue core.
// ----------------------------------------------------------------------------
// A directed burst covers empty pops, extreme and equal values, filling the
// store and pushes into a full store. Random segments with a shifting push
// bias follow, so the fill level wanders between empty and full. Every
// accepted transfer in is run through a software sorted list, and each
// transfer out is checked field by field against the oldest expected status.
// Both sides idle at random; the receiver holds off for long stretches and
// the sender now and then waits for the queue of results to run dry.
// ----------------------------------------------------------------------------
module tb_top;

    import smpq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int RAND_ITEMS  = 1780;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        t_op                op;
        logic signed [31:0] value;
        bit                 wait_for_drain;
    } t_queue_op;

    typedef struct {
        logic signed [31:0] min_value;
        logic               has_entries;
        logic [4:0]         entry_count;
        logic               push_dropped;
    } t_queue_status;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_op                    i_opcode = OP_PUSH;
    logic signed [31:0]     i_push_value = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [31:0]     o_min_value;
    logic                   o_has_entries;
    logic [4:0]             o_entry_count;
    logic                   o_push_dropped;

    t_queue_op      pending_ops[$];
    t_queue_status  expected_status[$];
    int             held_values[$];

    int  err_count = 0;
    int  ops_accepted = 0;
    int  total_ops = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  in_fire = 1'b0;
    int  tx_gap = 0;
    int  tx_steady = 0;
    int  rx_stall_left = 0;
    int  rx_steady = 0;
    int  hold_left = 0;
    int  next_hold_at = 400;

    sorted_min_priority_queue_core #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_min_value    (o_min_value),
        .o_has_entries  (o_has_entries),
        .o_entry_count  (o_entry_count),
        .o_push_dropped (o_push_dropped)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_queue_status apply_queue_op(t_queue_op req);
        t_queue_status st;
        int pos;
        st.push_dropped = 1'b0;
        if (req.op == OP_PUSH) begin
            if (held_values.size() >= DEPTH) begin
                st.push_dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < held_values.size() && held_values[pos] < req.value)
                    pos++;
                held_values.insert(pos, req.value);
            end
        end else if (held_values.size() != 0) begin
            void'(held_values.pop_front());
        end
        st.entry_count = 5'(held_values.size());
        st.has_entries = (held_values.size() != 0);
        st.min_value   = (held_values.size() != 0) ? held_values[0] : 0;
        return st;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap(inout int steady);
        int r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            steady = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: begin
                return $signed($urandom_range(0, 8)) - 32'sd4;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic add_op(input t_op op, input logic signed [31:0] value,
                          input bit wait_for_drain);
        t_queue_op req;
        req.op             = op;
        req.value          = value;
        req.wait_for_drain = wait_for_drain;
        pending_ops.insert(pending_ops.size(), req);
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        err_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // driver
    always @(negedge i_clk) begin
        t_queue_op req;
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         (!pending_ops[0].wait_for_drain || expected_status.size() == 0)) begin
                req = pending_ops.pop_front();
                i_opcode     <= req.op;
                i_push_value <= req.value;
                i_in_valid   <= 1'b1;
                tx_gap = pick_gap(tx_steady);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off every few hundred results
    always @(negedge i_clk) begin
        if (results_seen >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 700;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            rx_stall_left = pick_gap(rx_steady);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_queue_op     req;
        t_queue_status want;
        bit            in_xfer;
        bit            out_xfer;
        in_xfer  = i_rst_n && i_in_valid && !o_in_stall;
        out_xfer = i_rst_n && o_out_valid && !i_out_stall;
        in_fire <= in_xfer;
        if (in_xfer) begin
            req.op             = i_opcode;
            req.value          = i_push_value;
            req.wait_for_drain = 1'b0;
            want = apply_queue_op(req);
            expected_status.insert(expected_status.size(), want);
            ops_accepted++;
        end
        if (out_xfer) begin
            results_seen++;
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected transfer, count", o_entry_count, 0);
            end else begin
                want = expected_status.pop_front();
                if (o_min_value !== want.min_value)
                    report_mismatch("min_value", o_min_value, want.min_value);
                if (o_has_entries !== want.has_entries)
                    report_mismatch("has_entries", o_has_entries, want.has_entries);
                if (o_entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_entry_count, want.entry_count);
                if (o_push_dropped !== want.push_dropped)
                    report_mismatch("push_dropped", o_push_dropped, want.push_dropped);
            end
        end
        if (in_xfer || out_xfer) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int seg_left;
        int push_pct;
        int n;
        // empty pops, pop value ignored
        add_op(OP_POP, -32'sd1, 1'b0);
        add_op(OP_POP, 32'sd0, 1'b0);
        // extremes and equal values
        add_op(OP_PUSH, 32'sd0, 1'b0);
        add_op(OP_PUSH, 32'sh7fff_ffff, 1'b0);
        add_op(OP_PUSH, 32'sh8000_0000, 1'b0);
        add_op(OP_PUSH, -32'sd1, 1'b0);
        add_op(OP_PUSH, 32'sd1, 1'b0);
        add_op(OP_PUSH, 32'sd5, 1'b0);
        add_op(OP_PUSH, 32'sd5, 1'b0);
        add_op(OP_POP, 32'sh7fff_ffff, 1'b0);
        add_op(OP_POP, 32'sh8000_0000, 1'b0);
        // fill up, then push into a full store
        for (int k = 0; k < 11; k++)
            add_op(OP_PUSH, k * 3 - 10, 1'b0);
        add_op(OP_PUSH, 32'sh8000_0000, 1'b0);
        add_op(OP_PUSH, 32'sh7fff_ffff, 1'b0);
        add_op(OP_POP, 32'sd0, 1'b0);
        add_op(OP_PUSH, 32'sd2, 1'b1);

        seg_left = 0;
        push_pct = 50;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    default: push_pct = 78;
                endcase
            end
            seg_left--;
            add_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_value(),
                   (n % 450) == 449);
        end
        total_ops = pending_ops.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted != total_ops || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
